@@ rtl/pva_pkg.sv @@
// pva_pkg: shared constants and codes for the voice allocator.
// Function and action codes, voice count and derived widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pva_pkg;

    localparam int NUM_VOICES = 8;
    localparam int VOICE_W    = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

    // fixed field widths
    localparam int FUNC_W  = 3;
    localparam int NOTE_W  = 7;
    localparam int VAL_W   = 7;
    localparam int FIN_W   = 3;
    localparam int ACT_W   = 3;
    localparam int INDEX_W = 3;
    localparam int MASK_W  = 8;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_NOTE_ON    = 3'd0,
        FUNC_NOTE_OFF   = 3'd1,
        FUNC_FINISHED   = 3'd2,
        FUNC_POLY_AT    = 3'd3,
        FUNC_CHANNEL_AT = 3'd4
    } t_func;

    typedef enum logic [ACT_W-1:0] {
        ACT_NONE       = 3'd0,
        ACT_FREE       = 3'd1,
        ACT_RETRIG     = 3'd2,
        ACT_STEAL      = 3'd3,
        ACT_RELEASE    = 3'd4,
        ACT_FINISHED   = 3'd5,
        ACT_AFTERTOUCH = 3'd6
    } t_action;

endpackage

`default_nettype wire

@@ rtl/polyphonic_voice_allocator_top.sv @@
// polyphonic_voice_allocator_top: voice table with oldest-voice stealing.
// Depends on pva_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake                 Payload
// -------  ---------  ------------------------  ------------------------------------
// in       sink       i_in_valid / o_in_ready   i_func, i_note, i_note_velocity,
//                                               i_pressure, i_finished_voice
// out      source     o_out_valid / i_out_ready o_action, o_voice_index, o_voice_mask
//
// Timing: the result of a transfer on the in channel appears in the output
// register on the next cycle; one event per cycle is sustained as long as
// the out side takes results.
// The voice search, steal pick and age-rank update are one pass of logic
// between the voice table and the output register.
// Reset: synchronous, active low; clears the voice table, sets age ranks to
// the voice index and empties the output register.
// Stalls: a held result blocks new events only while i_out_ready is low.

module polyphonic_voice_allocator_top (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_in_valid,
    output logic                          o_in_ready,
    input  wire  [pva_pkg::FUNC_W-1:0]    i_func,
    input  wire  [pva_pkg::NOTE_W-1:0]    i_note,
    input  wire  [pva_pkg::VAL_W-1:0]     i_note_velocity,
    input  wire  [pva_pkg::VAL_W-1:0]     i_pressure,
    input  wire  [pva_pkg::FIN_W-1:0]     i_finished_voice,
    output logic                          o_out_valid,
    input  wire                           i_out_ready,
    output logic [pva_pkg::ACT_W-1:0]     o_action,
    output logic [pva_pkg::INDEX_W-1:0]   o_voice_index,
    output logic [pva_pkg::MASK_W-1:0]    o_voice_mask
);
    import pva_pkg::*;

    // voice table
    logic [NUM_VOICES-1:0]  r_active, n_active;
    logic [NOTE_W-1:0]      r_note     [NUM_VOICES], n_note     [NUM_VOICES];
    logic [VAL_W-1:0]       r_velocity [NUM_VOICES], n_velocity [NUM_VOICES];
    logic [VAL_W-1:0]       r_pressure [NUM_VOICES], n_pressure [NUM_VOICES];
    logic [VOICE_W-1:0]     r_rank     [NUM_VOICES], n_rank     [NUM_VOICES];

    // output register
    logic                   r_out_valid;
    t_action                r_action, n_action;
    logic [INDEX_W-1:0]     r_index, n_index;
    logic [MASK_W-1:0]      r_mask, n_mask;

    logic                   w_accept;
    logic [NUM_VOICES-1:0]  w_hit;        // inactive or same note
    logic [NUM_VOICES-1:0]  w_match;      // active and same note
    logic [VOICE_W-1:0]     w_first;      // lowest index in w_hit
    logic [VOICE_W-1:0]     w_oldest;     // voice at rank zero
    logic [VOICE_W-1:0]     w_sel;
    logic [VOICE_W-1:0]     w_fin;
    logic                   w_fin_ok;
    logic [NUM_VOICES-1:0]  w_vmask;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_fin    = VOICE_W'(i_finished_voice);
    assign w_fin_ok = 32'(i_finished_voice) < 32'(NUM_VOICES);

    // per-voice match flags, priority pick and oldest lookup
    always_comb begin
        w_first  = '0;
        w_oldest = '0;
        for (int i = 0; i < NUM_VOICES; i++) begin
            w_hit[i]   = !r_active[i] || (r_note[i] == i_note);
            w_match[i] = r_active[i] && (r_note[i] == i_note);
        end
        for (int i = NUM_VOICES - 1; i >= 0; i--) begin
            if (w_hit[i]) begin
                w_first = VOICE_W'(i);
            end
        end
        // ranks are a permutation, so exactly one voice holds rank zero
        for (int i = 0; i < NUM_VOICES; i++) begin
            if (r_rank[i] == '0) begin
                w_oldest = VOICE_W'(i);
            end
        end
    end

    assign w_sel = (|w_hit) ? w_first : w_oldest;

    // next table contents and result
    always_comb begin
        n_active   = r_active;
        n_note     = r_note;
        n_velocity = r_velocity;
        n_pressure = r_pressure;
        n_rank     = r_rank;
        n_action   = ACT_NONE;
        n_index    = '0;
        w_vmask    = '0;

        case (i_func)
            FUNC_NOTE_ON: begin
                if (!(|w_hit)) begin
                    n_action = ACT_STEAL;
                end else if (r_active[w_sel]) begin
                    n_action = ACT_RETRIG;
                end else begin
                    n_action = ACT_FREE;
                end
                n_note[w_sel]     = i_note;
                n_velocity[w_sel] = i_note_velocity;
                n_active[w_sel]   = 1'b1;
                // make newest: ranks above the chosen voice move down one
                for (int i = 0; i < NUM_VOICES; i++) begin
                    if (r_rank[i] > r_rank[w_sel]) begin
                        n_rank[i] = r_rank[i] - 1'b1;
                    end
                end
                n_rank[w_sel]  = VOICE_W'(NUM_VOICES - 1);
                n_index        = INDEX_W'(w_sel);
                w_vmask[w_sel] = 1'b1;
            end
            FUNC_NOTE_OFF: begin
                n_action = ACT_RELEASE;
                w_vmask  = w_match;
            end
            FUNC_FINISHED: begin
                if (w_fin_ok) begin
                    n_active[w_fin] = 1'b0;
                    n_action        = ACT_FINISHED;
                    n_index         = INDEX_W'(w_fin);
                    w_vmask[w_fin]  = 1'b1;
                end
            end
            FUNC_POLY_AT: begin
                for (int i = 0; i < NUM_VOICES; i++) begin
                    if (w_match[i]) begin
                        n_pressure[i] = i_pressure;
                    end
                end
                n_action = ACT_AFTERTOUCH;
                w_vmask  = w_match;
            end
            FUNC_CHANNEL_AT: begin
                for (int i = 0; i < NUM_VOICES; i++) begin
                    n_pressure[i] = i_pressure;
                end
                n_action = ACT_AFTERTOUCH;
                w_vmask  = '1;
            end
            default: begin
                n_action = ACT_NONE;
            end
        endcase

        // voices above the mask width fall outside
        n_mask = MASK_W'(w_vmask);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_active    <= '0;
            for (int i = 0; i < NUM_VOICES; i++) begin
                r_note[i]     <= '0;
                r_velocity[i] <= '0;
                r_pressure[i] <= '0;
                r_rank[i]     <= VOICE_W'(i);
            end
        end else begin
            if (w_accept) begin
                r_out_valid <= 1'b1;
                r_active    <= n_active;
                r_note      <= n_note;
                r_velocity  <= n_velocity;
                r_pressure  <= n_pressure;
                r_rank      <= n_rank;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded on every transfer in
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action <= n_action;
            r_index  <= n_index;
            r_mask   <= n_mask;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_action      = r_action;
    assign o_voice_index = r_index;
    assign o_voice_mask  = r_mask;

endmodule

`default_nettype wire

@@ rtl/pva_checker.sv @@
// pva_checker: port-level checks for the voice allocator, bound to the top.
// Depends on pva_pkg and polyphonic_voice_allocator_top.
`timescale 1ns / 1ps
`default_nettype none

module pva_checker (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_in_valid,
    input  wire                           o_in_ready,
    input  wire                           o_out_valid,
    input  wire                           i_out_ready,
    input  wire  [pva_pkg::ACT_W-1:0]     o_action,
    input  wire  [pva_pkg::INDEX_W-1:0]   o_voice_index,
    input  wire  [pva_pkg::MASK_W-1:0]    o_voice_mask
);
    import pva_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_action) && $stable(o_voice_index)
            && $stable(o_voice_mask))
        else $error("result changed while stalled");

    // every transfer in yields a result on the next cycle
    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("transfer in gave no result");

    // empty output register never blocks the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked with empty output");

    // note-on results name exactly one voice, the one in voice_index
    a_note_on_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_action == ACT_FREE || o_action == ACT_RETRIG
            || o_action == ACT_STEAL) |->
            $onehot(o_voice_mask) && o_voice_mask[o_voice_index])
        else $error("note-on mask does not match voice index");

    // ignored events report nothing
    a_none_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_action == ACT_NONE |->
            o_voice_mask == '0 && o_voice_index == '0)
        else $error("ignored event reported a voice");

endmodule

bind polyphonic_voice_allocator_top pva_checker u_pva_checker (.*);

`default_nettype wire

@@ dv/testbench.sv @@
// testbench: self-checking bench for polyphonic_voice_allocator_top.
// Runs a directed event table, then random MIDI-style traffic checked by a voice table model.
// Depends on pva_pkg and the allocator RTL.
`timescale 1ns / 1ps

module testbench;
    import pva_pkg::*;

    // Undefined function codes; the block must answer them with ACT_NONE.
    localparam logic [FUNC_W-1:0] FUNC_RSVD_5 = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_RSVD_6 = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_RSVD_7 = 3'd7;

    localparam int CYCLE_LIMIT = 400000;  // well above the slowest legal run
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        t_action              act;
        logic [INDEX_W-1:0]   idx;
        logic [MASK_W-1:0]    mask;
    } t_voice_outcome;

    // One directed event; 'typed' marks rows whose outcome is written out by hand.
    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [NOTE_W-1:0]  note;
        logic [VAL_W-1:0]   vel;
        logic [VAL_W-1:0]   pres;
        logic [FIN_W-1:0]   fin;
        logic               typed;
        t_voice_outcome     want;
    } t_event_row;

    localparam t_voice_outcome NO_CARE = '{ACT_NONE, 3'd0, 8'h00};

    // Directed table: reset state, retrigger vs free start, release with and
    // without a match, both aftertouch kinds at the extremes, finishing an
    // inactive voice, the undefined functions, filling the table and stealing.
    localparam int NUM_ROWS = 25;
    localparam t_event_row DIRECTED_ROWS [NUM_ROWS] = '{
        '{FUNC_NOTE_ON,    7'd60,  7'd127, 7'd0,   3'd0, 1'b1, '{ACT_FREE,       3'd0, 8'h01}},
        '{FUNC_NOTE_ON,    7'd60,  7'd0,   7'd0,   3'd0, 1'b1, '{ACT_RETRIG,     3'd0, 8'h01}},
        '{FUNC_NOTE_OFF,   7'd61,  7'd0,   7'd0,   3'd0, 1'b1, '{ACT_RELEASE,    3'd0, 8'h00}},
        '{FUNC_NOTE_OFF,   7'd60,  7'd0,   7'd0,   3'd0, 1'b1, '{ACT_RELEASE,    3'd0, 8'h01}},
        '{FUNC_POLY_AT,    7'd60,  7'd0,   7'd127, 3'd0, 1'b1, '{ACT_AFTERTOUCH, 3'd0, 8'h01}},
        '{FUNC_POLY_AT,    7'd5,   7'd0,   7'd64,  3'd0, 1'b1, '{ACT_AFTERTOUCH, 3'd0, 8'h00}},
        '{FUNC_CHANNEL_AT, 7'd0,   7'd0,   7'd0,   3'd0, 1'b1, '{ACT_AFTERTOUCH, 3'd0, 8'hff}},
        '{FUNC_CHANNEL_AT, 7'd127, 7'd127, 7'd127, 3'd7, 1'b1, '{ACT_AFTERTOUCH, 3'd0, 8'hff}},
        '{FUNC_FINISHED,   7'd0,   7'd0,   7'd0,   3'd0, 1'b1, '{ACT_FINISHED,   3'd0, 8'h01}},
        '{FUNC_NOTE_ON,    7'd60,  7'd64,  7'd0,   3'd0, 1'b1, '{ACT_FREE,       3'd0, 8'h01}},
        '{FUNC_FINISHED,   7'd0,   7'd0,   7'd0,   3'd7, 1'b1, '{ACT_FINISHED,   3'd7, 8'h80}},
        '{FUNC_RSVD_5,     7'd127, 7'd127, 7'd127, 3'd7, 1'b1, '{ACT_NONE,       3'd0, 8'h00}},
        '{FUNC_RSVD_6,     7'd60,  7'd1,   7'd1,   3'd1, 1'b1, '{ACT_NONE,       3'd0, 8'h00}},
        '{FUNC_RSVD_7,     7'd60,  7'd127, 7'd0,   3'd0, 1'b1, '{ACT_NONE,       3'd0, 8'h00}},
        '{FUNC_NOTE_ON,    7'd0,   7'd1,   7'd0,   3'd0, 1'b0, NO_CARE},
        '{FUNC_NOTE_ON,    7'd127, 7'd127, 7'd0,   3'd0, 1'b0, NO_CARE},
        '{FUNC_NOTE_ON,    7'd1,   7'd10,  7'd0,   3'd0, 1'b0, NO_CARE},
        '{FUNC_NOTE_ON,    7'd2,   7'd20,  7'd0,   3'd0, 1'b0, NO_CARE},
        '{FUNC_NOTE_ON,    7'd3,   7'd30,  7'd0,   3'd0, 1'b0, NO_CARE},
        '{FUNC_NOTE_ON,    7'd4,   7'd40,  7'd0,   3'd0, 1'b0, NO_CARE},
        '{FUNC_NOTE_ON,    7'd5,   7'd50,  7'd0,   3'd0, 1'b0, NO_CARE},
        '{FUNC_NOTE_ON,    7'd99,  7'd127, 7'd0,   3'd0, 1'b0, NO_CARE},
        '{FUNC_NOTE_ON,    7'd100, 7'd85,  7'd0,   3'd0, 1'b0, NO_CARE},
        '{FUNC_NOTE_OFF,   7'd99,  7'd0,   7'd0,   3'd0, 1'b0, NO_CARE},
        '{FUNC_FINISHED,   7'd0,   7'd0,   7'd0,   3'd3, 1'b1, '{ACT_FINISHED,   3'd3, 8'h08}}
    };

    // ---------------------------------------------------------------- DUT I/O
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [FUNC_W-1:0]    i_func = '0;
    logic [NOTE_W-1:0]    i_note = '0;
    logic [VAL_W-1:0]     i_note_velocity = '0;
    logic [VAL_W-1:0]     i_pressure = '0;
    logic [FIN_W-1:0]     i_finished_voice = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [ACT_W-1:0]     o_action;
    logic [INDEX_W-1:0]   o_voice_index;
    logic [MASK_W-1:0]    o_voice_mask;

    polyphonic_voice_allocator_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_func           (i_func),
        .i_note           (i_note),
        .i_note_velocity  (i_note_velocity),
        .i_pressure       (i_pressure),
        .i_finished_voice (i_finished_voice),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_action         (o_action),
        .o_voice_index    (o_voice_index),
        .o_voice_mask     (o_voice_mask)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------- voice table model
    logic                 tbl_active [NUM_VOICES];
    logic [NOTE_W-1:0]    tbl_note   [NUM_VOICES];
    logic [VAL_W-1:0]     tbl_vel    [NUM_VOICES];
    logic [VAL_W-1:0]     tbl_pres   [NUM_VOICES];
    logic [VOICE_W-1:0]   tbl_rank   [NUM_VOICES];  // 0 = oldest

    t_voice_outcome voice_outcomes [$];   // outcomes still owed by the block
    int  fail_count = 0;
    int  cycle_count = 0;
    bit  in_idle_on = 1'b0;               // sender inserts gaps
    bit  out_idle_on = 1'b0;              // receiver drops ready
    int  ready_hold = 0;

    function automatic logic [MASK_W-1:0] voice_bit(input int v);
        return (v < MASK_W) ? (MASK_W'(1) << v) : '0;
    endfunction

    // Apply one event to the table and return the result the block owes for it.
    function automatic t_voice_outcome voice_table_step(
        input logic [FUNC_W-1:0] func, input logic [NOTE_W-1:0] note,
        input logic [VAL_W-1:0] vel, input logic [VAL_W-1:0] pres,
        input logic [FIN_W-1:0] fin);
        t_voice_outcome res;
        int pick;
        int oldest;
        logic [VOICE_W-1:0] old_rank;
        res = '{ACT_NONE, '0, '0};
        case (func)
            FUNC_NOTE_ON: begin
                pick = -1;
                for (int i = 0; i < NUM_VOICES; i++) begin
                    if (pick < 0 && (!tbl_active[i] || tbl_note[i] == note)) pick = i;
                end
                if (pick >= 0) begin
                    res.act = tbl_active[pick] ? ACT_RETRIG : ACT_FREE;
                end else begin
                    oldest = 0;
                    for (int i = 1; i < NUM_VOICES; i++) begin
                        if (tbl_rank[i] < tbl_rank[oldest]) oldest = i;
                    end
                    pick = oldest;
                    res.act = ACT_STEAL;
                end
                tbl_note[pick]   = note;
                tbl_vel[pick]    = vel;
                tbl_active[pick] = 1'b1;
                // promote to newest: everything ranked above it slides down
                old_rank = tbl_rank[pick];
                for (int i = 0; i < NUM_VOICES; i++) begin
                    if (tbl_rank[i] > old_rank) tbl_rank[i] = tbl_rank[i] - 1'b1;
                end
                tbl_rank[pick] = VOICE_W'(NUM_VOICES - 1);
                res.idx  = INDEX_W'(pick);
                res.mask = voice_bit(pick);
            end
            FUNC_NOTE_OFF: begin
                for (int i = 0; i < NUM_VOICES; i++) begin
                    if (tbl_active[i] && tbl_note[i] == note) res.mask |= voice_bit(i);
                end
                res.act = ACT_RELEASE;
            end
            FUNC_FINISHED: begin
                if (int'(fin) < NUM_VOICES) begin
                    tbl_active[fin] = 1'b0;
                    res.act  = ACT_FINISHED;
                    res.idx  = INDEX_W'(fin);
                    res.mask = voice_bit(int'(fin));
                end
            end
            FUNC_POLY_AT: begin
                for (int i = 0; i < NUM_VOICES; i++) begin
                    if (tbl_active[i] && tbl_note[i] == note) begin
                        tbl_pres[i] = pres;
                        res.mask |= voice_bit(i);
                    end
                end
                res.act = ACT_AFTERTOUCH;
            end
            FUNC_CHANNEL_AT: begin
                for (int i = 0; i < NUM_VOICES; i++) begin
                    tbl_pres[i] = pres;
                    res.mask |= voice_bit(i);
                end
                res.act = ACT_AFTERTOUCH;
            end
            default: ;  // undefined codes leave the table alone
        endcase
        return res;
    endfunction

    // Mostly back-to-back, some short gaps, a few long ones.
    function automatic int pick_gap(input bit enabled);
        int r;
        if (!enabled) return 0;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    // --------------------------------------------------------------- sender
    // Drives one event and waits for its transfer. Valid is only lowered when
    // a gap is wanted, so back-to-back events keep it high.
    task automatic send_event(
        input logic [FUNC_W-1:0] func, input logic [NOTE_W-1:0] note,
        input logic [VAL_W-1:0] vel, input logic [VAL_W-1:0] pres,
        input logic [FIN_W-1:0] fin, input logic typed, input t_voice_outcome want);
        int gap;
        t_voice_outcome predicted;
        gap = pick_gap(in_idle_on);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_func           <= func;
        i_note           <= note;
        i_note_velocity  <= vel;
        i_pressure       <= pres;
        i_finished_voice <= fin;
        do @(posedge i_clk); while (!o_in_ready);
        // transfer happened at this edge
        predicted = voice_table_step(func, note, vel, pres, fin);
        voice_outcomes.push_back(typed ? want : predicted);
    endtask

    // Note of some sounding voice, or any note when nothing is sounding.
    function automatic logic [NOTE_W-1:0] sounding_note();
        int live [$];
        for (int i = 0; i < NUM_VOICES; i++) begin
            if (tbl_active[i]) live.push_back(i);
        end
        if (live.size() == 0) return NOTE_W'($urandom_range(0, 127));
        return tbl_note[live[$urandom_range(0, live.size() - 1)]];
    endfunction

    function automatic logic [FIN_W-1:0] sounding_voice();
        int live [$];
        for (int i = 0; i < NUM_VOICES; i++) begin
            if (tbl_active[i]) live.push_back(i);
        end
        if (live.size() == 0) return FIN_W'($urandom_range(0, 7));
        return FIN_W'(live[$urandom_range(0, live.size() - 1)]);
    endfunction

    // Random event biased toward musically sensible traffic: a narrow note
    // pool so retriggers and steals happen, and releases, finishes and
    // aftertouch that mostly hit voices that are actually sounding.
    task automatic send_random_event();
        int                  r;
        logic [FUNC_W-1:0]   func;
        logic [NOTE_W-1:0]   note;
        logic [FIN_W-1:0]    fin;
        r    = $urandom_range(0, 99);
        note = ($urandom_range(0, 99) < 70) ? NOTE_W'(48 + $urandom_range(0, 11))
                                            : NOTE_W'($urandom_range(0, 127));
        fin  = FIN_W'($urandom_range(0, 7));
        if (r < 35) begin
            func = FUNC_NOTE_ON;
        end else if (r < 50) begin
            func = FUNC_NOTE_OFF;
            if ($urandom_range(0, 99) < 65) note = sounding_note();
        end else if (r < 75) begin
            func = FUNC_FINISHED;
            if ($urandom_range(0, 99) < 70) fin = sounding_voice();
        end else if (r < 87) begin
            func = FUNC_POLY_AT;
            if ($urandom_range(0, 99) < 65) note = sounding_note();
        end else if (r < 93) begin
            func = FUNC_CHANNEL_AT;
        end else begin
            func = FUNC_W'($urandom_range(0, 7));  // any code, undefined ones included
        end
        send_event(func, note, VAL_W'($urandom_range(0, 127)),
                   VAL_W'($urandom_range(0, 127)), fin, 1'b0, NO_CARE);
    endtask

    // Hold off new events until the block has returned everything it owes.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (voice_outcomes.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------- receiver
    always @(posedge i_clk) begin : result_side
        t_voice_outcome want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (voice_outcomes.size() == 0) begin
                note_failure($sformatf("result with nothing pending: act=%0d idx=%0d mask=%h",
                                       o_action, o_voice_index, o_voice_mask));
            end else begin
                want = voice_outcomes.pop_front();
                if (o_action !== want.act || o_voice_index !== want.idx ||
                    o_voice_mask !== want.mask) begin
                    note_failure($sformatf("act %0d/%0d idx %0d/%0d mask %h/%h (exp/got)",
                                           want.act, o_action, want.idx, o_voice_index,
                                           want.mask, o_voice_mask));
                end
            end
        end
        // ready: either held low for a random stall or high
        if (ready_hold != 0) begin
            i_out_ready <= 1'b0;
            ready_hold  <= ready_hold - 1;
        end else begin
            i_out_ready <= 1'b1;
            if (out_idle_on && $urandom_range(0, 99) < 25) ready_hold <= pick_gap(1'b1);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------ main flow
    initial begin : stimulus
        t_event_row row;
        for (int i = 0; i < NUM_VOICES; i++) begin
            tbl_active[i] = 1'b0;
            tbl_note[i]   = '0;
            tbl_vel[i]    = '0;
            tbl_pres[i]   = '0;
            tbl_rank[i]   = VOICE_W'(i);
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, light idling on both sides
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
        for (int i = 0; i < NUM_ROWS; i++) begin
            row = DIRECTED_ROWS[i];
            send_event(row.func, row.note, row.vel, row.pres, row.fin, row.typed, row.want);
        end
        drain();

        // full rate, no idling anywhere
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        repeat (120) send_random_event();
        drain();   // sender waits for every outstanding result

        // idling on both sides
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
        repeat (250) send_random_event();
        drain();

        // steady sender against a stalling receiver (backpressure)
        in_idle_on  = 1'b0;
        out_idle_on = 1'b1;
        repeat (90) send_random_event();

        // bursty sender, receiver always ready
        in_idle_on  = 1'b1;
        out_idle_on = 1'b0;
        repeat (90) send_random_event();

        drain();
        repeat (8) @(posedge i_clk);   // catch any stray extra result

        if (fail_count == 0 && voice_outcomes.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/pva_pkg.sv
rtl/polyphonic_voice_allocator_top.sv
rtl/pva_checker.sv
dv/testbench.sv
